### rtl/ptd_pkg.sv
// Shared widths, types and region codes for the point-to-triangle distance pipeline.
package ptd_pkg;

    localparam int CW    = 16;
    localparam int NCOORD = 12;
    localparam int DIFW  = 17;
    localparam int PRW   = 34;
    localparam int DW    = 36;
    localparam int HW    = 18;
    localparam int VW    = 74;
    localparam int RW    = 21;
    localparam int MAGW  = 20;
    localparam int SQW   = 40;
    localparam int ACCW  = 42;
    localparam int DISTW = 34;

    localparam logic [DISTW-1:0] DIST_MAX = '1;

    typedef logic signed [CW-1:0]   coord_t;
    typedef logic signed [DIFW-1:0] dif_t;
    typedef dif_t [2:0]             vec3_t;
    typedef logic signed [DW-1:0]   dot_t;
    typedef logic signed [VW-1:0]   wide_t;

    typedef enum logic [2:0] {
        REG_VA   = 3'd0,
        REG_VB   = 3'd1,
        REG_EAB  = 3'd2,
        REG_VC   = 3'd3,
        REG_EAC  = 3'd4,
        REG_EBC  = 3'd5,
        REG_FACE = 3'd6
    } region_t;

    typedef struct packed {
        vec3_t ab;
        vec3_t ac;
        vec3_t bc;
        vec3_t ap;
        vec3_t bp;
        vec3_t cp;
    } geom_t;

    typedef struct packed {
        vec3_t   pb;
        vec3_t   e1;
        vec3_t   e2;
        region_t region;
        logic    degen;
    } tail_t;

endpackage

### rtl/ptd_dots.sv
// Edge and offset vectors and the six dot products, three register stages.
module ptd_dots import ptd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  coord_t [NCOORD-1:0] coord,
    output logic              out_valid,
    output dot_t [5:0]        dot,
    output geom_t             geom
);

    logic                 v1_reg, v2_reg, v3_reg;
    geom_t                g1_reg, g2_reg, g3_reg;
    geom_t                g1_next;
    logic signed [PRW-1:0] prod_reg [0:5][0:2];
    logic signed [PRW-1:0] prod_next [0:5][0:2];
    dot_t [5:0]           dot_reg;
    dot_t [5:0]           dot_next;
    vec3_t                lhs [0:5];
    vec3_t                rhs [0:5];

    function automatic dif_t ext(input coord_t c);
        return {c[CW-1], c};
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g1_next.ab[i] = ext(coord[6 + i]) - ext(coord[3 + i]);
            g1_next.ac[i] = ext(coord[9 + i]) - ext(coord[3 + i]);
            g1_next.bc[i] = ext(coord[9 + i]) - ext(coord[6 + i]);
            g1_next.ap[i] = ext(coord[i]) - ext(coord[3 + i]);
            g1_next.bp[i] = ext(coord[i]) - ext(coord[6 + i]);
            g1_next.cp[i] = ext(coord[i]) - ext(coord[9 + i]);
        end
    end

    always_comb begin
        lhs[0] = g1_reg.ab; rhs[0] = g1_reg.ap;
        lhs[1] = g1_reg.ac; rhs[1] = g1_reg.ap;
        lhs[2] = g1_reg.ab; rhs[2] = g1_reg.bp;
        lhs[3] = g1_reg.ac; rhs[3] = g1_reg.bp;
        lhs[4] = g1_reg.ab; rhs[4] = g1_reg.cp;
        lhs[5] = g1_reg.ac; rhs[5] = g1_reg.cp;
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
                prod_next[k][i] = $signed(lhs[k][i]) * $signed(rhs[k][i]);
            end
        end
        for (int k = 0; k < 6; k++) begin
            dot_next[k] = DW'(prod_reg[k][0]) + DW'(prod_reg[k][1]) + DW'(prod_reg[k][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg   <= g1_next;
            g2_reg   <= g1_reg;
            g3_reg   <= g2_reg;
            prod_reg <= prod_next;
            dot_reg  <= dot_next;
        end
    end

    assign out_valid = v3_reg;
    assign dot       = dot_reg;
    assign geom      = g3_reg;

endmodule

### rtl/ptd_region.sv
// Barycentric cross terms, region selection and divider setup, four register stages.
module ptd_region import ptd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       adv,
    input  logic       in_valid,
    input  dot_t [5:0] dot,
    input  geom_t      geom,
    output logic       out_valid,
    output wide_t      num0,
    output wide_t      den0,
    output wide_t      num1,
    output wide_t      den1,
    output tail_t      tail
);

    typedef struct packed {
        dot_t [5:0] d;
        dot_t       d13;
        dot_t       d26;
        dot_t       d43;
        dot_t       d56;
    } dside_t;

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    geom_t  g1_reg, g2_reg, g3_reg;
    dside_t s1_reg, s2_reg, s3_reg;
    dside_t s1_next;

    logic signed [DW+HW:0]   lo_reg [0:5];
    logic signed [DW+HW-1:0] hi_reg [0:5];
    logic signed [DW+HW:0]   lo_next [0:5];
    logic signed [DW+HW-1:0] hi_next [0:5];
    wide_t                   pr_reg [0:5];
    wide_t                   pr_next [0:5];
    wide_t                   va_reg, vb_reg, vc_reg;

    wide_t num0_reg, den0_reg, num1_reg, den1_reg;
    wide_t num0_next, den0_next, num1_next, den1_next;
    tail_t tail_reg, tail_next;
    wide_t face_den;
    dot_t  xs [0:5];
    dot_t  ys [0:5];

    always_comb begin
        s1_next.d   = dot;
        s1_next.d13 = dot[0] - dot[2];
        s1_next.d26 = dot[1] - dot[5];
        s1_next.d43 = dot[3] - dot[2];
        s1_next.d56 = dot[4] - dot[5];
        xs[0] = dot[0]; ys[0] = dot[3];
        xs[1] = dot[2]; ys[1] = dot[1];
        xs[2] = dot[4]; ys[2] = dot[1];
        xs[3] = dot[0]; ys[3] = dot[5];
        xs[4] = dot[2]; ys[4] = dot[5];
        xs[5] = dot[4]; ys[5] = dot[3];
        for (int j = 0; j < 6; j++) begin
            lo_next[j] = $signed(xs[j]) * $signed({1'b0, ys[j][HW-1:0]});
            hi_next[j] = $signed(xs[j]) * $signed(ys[j][DW-1:HW]);
        end
        for (int j = 0; j < 6; j++) begin
            pr_next[j] = (VW'(hi_reg[j]) <<< HW) + VW'(lo_reg[j]);
        end
    end

    always_comb begin
        face_den  = va_reg + vb_reg + vc_reg;
        num0_next = '0;
        den0_next = wide_t'(1);
        num1_next = '0;
        den1_next = wide_t'(1);
        tail_next.pb     = g3_reg.ap;
        tail_next.e1     = g3_reg.ab;
        tail_next.e2     = g3_reg.ac;
        tail_next.region = REG_VA;
        tail_next.degen  = 1'b0;
        priority if (s3_reg.d[0] <= 0 && s3_reg.d[1] <= 0) begin
            tail_next.region = REG_VA;
        end else if (s3_reg.d[2] >= 0 && s3_reg.d[3] <= s3_reg.d[2]) begin
            tail_next.region = REG_VB;
            tail_next.pb     = g3_reg.bp;
        end else if (vc_reg <= 0 && s3_reg.d[0] >= 0 && s3_reg.d[2] <= 0) begin
            tail_next.region = REG_EAB;
            num0_next = VW'(s3_reg.d[0]);
            den0_next = VW'(s3_reg.d13);
        end else if (s3_reg.d[5] >= 0 && s3_reg.d[4] <= s3_reg.d[5]) begin
            tail_next.region = REG_VC;
            tail_next.pb     = g3_reg.cp;
        end else if (vb_reg <= 0 && s3_reg.d[1] >= 0 && s3_reg.d[5] <= 0) begin
            tail_next.region = REG_EAC;
            num1_next = VW'(s3_reg.d[1]);
            den1_next = VW'(s3_reg.d26);
        end else if (va_reg <= 0 && s3_reg.d43 >= 0 && s3_reg.d56 >= 0) begin
            tail_next.region = REG_EBC;
            tail_next.pb     = g3_reg.bp;
            tail_next.e1     = g3_reg.bc;
            num0_next = VW'(s3_reg.d43);
            den0_next = VW'(s3_reg.d43) + VW'(s3_reg.d56);
        end else begin
            tail_next.region = REG_FACE;
            tail_next.degen  = (face_den <= 0);
            num0_next = vb_reg;
            den0_next = face_den;
            num1_next = vc_reg;
            den1_next = face_den;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg   <= geom;
            g2_reg   <= g1_reg;
            g3_reg   <= g2_reg;
            s1_reg   <= s1_next;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            pr_reg   <= pr_next;
            vc_reg   <= pr_reg[0] - pr_reg[1];
            vb_reg   <= pr_reg[2] - pr_reg[3];
            va_reg   <= pr_reg[4] - pr_reg[5];
            num0_reg <= num0_next;
            den0_reg <= den0_next;
            num1_reg <= num1_next;
            den1_reg <= den1_next;
            tail_reg <= tail_next;
        end
    end

    assign out_valid = v4_reg;
    assign num0      = num0_reg;
    assign den0      = den0_reg;
    assign num1      = num1_reg;
    assign den1      = den1_reg;
    assign tail      = tail_reg;

endmodule

### rtl/ptd_div.sv
// Two restoring divider lanes for the clamped weights, one quotient bit per stage.
module ptd_div import ptd_pkg::*; #(
    parameter int QB = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  wide_t         num0,
    input  wide_t         den0,
    input  wide_t         num1,
    input  wide_t         den1,
    input  tail_t         tail_in,
    output logic          out_valid,
    output logic [QB:0]   wt_v,
    output logic [QB:0]   wt_w,
    output tail_t         tail_out
);

    logic            vld_reg  [0:QB];
    tail_t           tail_reg [0:QB];
    logic [VW-1:0]   rem_reg  [0:QB][0:1];
    logic [VW-1:0]   den_reg  [0:QB][0:1];
    logic [QB-1:0]   q_reg    [0:QB][0:1];
    logic            zero_reg [0:QB][0:1];
    logic            full_reg [0:QB][0:1];

    logic [VW-1:0]   rem_next [0:QB-1][0:1];
    logic [QB-1:0]   q_next   [0:QB-1][0:1];
    logic [VW-1:0]   rem_sh   [0:QB-1][0:1];
    wide_t           nums [0:1];
    wide_t           dens [0:1];
    logic            zero_in [0:1];
    logic            full_in [0:1];
    logic [QB:0]     wt [0:1];

    always_comb begin
        nums[0] = num0;
        dens[0] = den0;
        nums[1] = num1;
        dens[1] = den1;
        for (int l = 0; l < 2; l++) begin
            zero_in[l] = (dens[l] <= 0) || (nums[l] < 0);
            full_in[l] = !zero_in[l] && (nums[l] >= dens[l]);
        end
        for (int k = 0; k < QB; k++) begin
            for (int l = 0; l < 2; l++) begin
                rem_sh[k][l] = {rem_reg[k][l][VW-2:0], 1'b0};
                if (rem_sh[k][l] >= den_reg[k][l]) begin
                    rem_next[k][l] = rem_sh[k][l] - den_reg[k][l];
                    q_next[k][l]   = {q_reg[k][l][QB-2:0], 1'b1};
                end else begin
                    rem_next[k][l] = rem_sh[k][l];
                    q_next[k][l]   = {q_reg[k][l][QB-2:0], 1'b0};
                end
            end
        end
        for (int l = 0; l < 2; l++) begin
            if (full_reg[QB][l]) begin
                wt[l] = {1'b1, {QB{1'b0}}};
            end else if (zero_reg[QB][l]) begin
                wt[l] = '0;
            end else begin
                wt[l] = {1'b0, q_reg[QB][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= QB; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < QB; k++) begin
                vld_reg[k + 1] <= vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tail_reg[0] <= tail_in;
            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l]  <= (zero_in[l] || full_in[l]) ? '0 : VW'(nums[l]);
                den_reg[0][l]  <= VW'(dens[l]);
                q_reg[0][l]    <= '0;
                zero_reg[0][l] <= zero_in[l];
                full_reg[0][l] <= full_in[l];
            end
            for (int k = 0; k < QB; k++) begin
                tail_reg[k + 1] <= tail_reg[k];
                for (int l = 0; l < 2; l++) begin
                    rem_reg[k + 1][l]  <= rem_next[k][l];
                    den_reg[k + 1][l]  <= den_reg[k][l];
                    q_reg[k + 1][l]    <= q_next[k][l];
                    zero_reg[k + 1][l] <= zero_reg[k][l];
                    full_reg[k + 1][l] <= full_reg[k][l];
                end
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign wt_v      = wt[0];
    assign wt_w      = wt[1];
    assign tail_out  = tail_reg[QB];

endmodule

### rtl/ptd_dist.sv
// Closest-point offset, rounding, squaring and saturating sum, four register stages.
module ptd_dist import ptd_pkg::*; #(
    parameter int QB = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [QB:0]       wt_v,
    input  logic [QB:0]       wt_w,
    input  tail_t             tail_in,
    output logic              out_valid,
    output logic [DISTW-1:0]  dist_sq,
    output logic [2:0]        region,
    output logic              degenerate
);

    localparam int MW = DIFW + QB + 2;
    localparam int SW = QB + RW;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [MW-1:0]  m1_reg [0:2];
    logic signed [MW-1:0]  m2_reg [0:2];
    logic signed [MW-1:0]  m1_next [0:2];
    logic signed [MW-1:0]  m2_next [0:2];
    vec3_t                 pb_reg;
    logic signed [RW-1:0]  r_reg [0:2];
    logic signed [RW-1:0]  r_next [0:2];
    logic signed [SW-1:0]  s_val [0:2];
    logic signed [SW-1:0]  t_val [0:2];
    logic [RW-1:0]         neg_r [0:2];
    logic [MAGW-1:0]       mag [0:2];
    logic [SQW-1:0]        sq_reg [0:2];
    logic [SQW-1:0]        sq_next [0:2];
    logic [ACCW-1:0]       acc;
    logic [DISTW-1:0]      dist_reg;
    logic [2:0]            reg1_reg, reg2_reg, reg3_reg, reg4_reg;
    logic                  dg1_reg, dg2_reg, dg3_reg, dg4_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m1_next[i] = $signed(tail_in.e1[i]) * $signed({1'b0, wt_v});
            m2_next[i] = $signed(tail_in.e2[i]) * $signed({1'b0, wt_w});
            s_val[i]   = (SW'($signed(pb_reg[i])) <<< QB) - SW'(m1_reg[i]) - SW'(m2_reg[i]);
            t_val[i]   = s_val[i] + (SW'(1) <<< (QB - 1));
            r_next[i]  = t_val[i][SW-1:QB];
            neg_r[i]   = -r_reg[i];
            mag[i]     = r_reg[i][RW-1] ? neg_r[i][MAGW-1:0] : r_reg[i][MAGW-1:0];
            sq_next[i] = SQW'(mag[i]) * SQW'(mag[i]);
        end
        acc = ACCW'(sq_reg[0]) + ACCW'(sq_reg[1]) + ACCW'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            pb_reg   <= tail_in.pb;
            r_reg    <= r_next;
            sq_reg   <= sq_next;
            dist_reg <= (acc > ACCW'(DIST_MAX)) ? DIST_MAX : acc[DISTW-1:0];
            reg1_reg <= tail_in.region;
            reg2_reg <= reg1_reg;
            reg3_reg <= reg2_reg;
            reg4_reg <= reg3_reg;
            dg1_reg  <= tail_in.degen;
            dg2_reg  <= dg1_reg;
            dg3_reg  <= dg2_reg;
            dg4_reg  <= dg3_reg;
        end
    end

    assign out_valid  = v4_reg;
    assign dist_sq    = dist_reg;
    assign region     = reg4_reg;
    assign degenerate = dg4_reg;

endmodule

### rtl/point_triangle_distance_sq_top.sv
// Top level of the point-to-triangle squared distance pipeline.
//
// s_ channel: one beat carries a query point and three triangle vertices,
// twelve signed Q3.13 coordinates. m_ channel: one beat carries the squared
// distance (26 fraction bits, saturating), the winning Voronoi region and
// the degenerate-face flag.
// Throughput: one beat per cycle, with no gap between beats, while m_tready is high.
// Pipeline: three stages of dot products, four of cross terms and region
// choice, divider lanes that produce one quotient bit per stage, and four
// of distance assembly.
// Reset clears every stage valid bit; the pipeline comes up empty and
// ready. When the receiver stalls with a result waiting, the whole pipeline
// holds in place and s_tready drops; no beat is lost or repeated.
module point_triangle_distance_sq_top import ptd_pkg::*; #(
    parameter int QUOT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // dist_sq[33:0], region[36:34], degenerate[37], zero fill[39:38]
    output logic [39:0]  m_tdata
);

    logic                 adv;
    coord_t [NCOORD-1:0]  coord;
    logic                 dots_valid;
    dot_t [5:0]           dots;
    geom_t                geom;
    logic                 rg_valid;
    wide_t                num0, den0, num1, den1;
    tail_t                rg_tail, dv_tail;
    logic                 dv_valid;
    logic [QUOT_FRAC_BITS:0] wt_v, wt_w;
    logic [DISTW-1:0]     dist_sq;
    logic [2:0]           region;
    logic                 degenerate;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int i = 0; i < NCOORD; i++) begin
            coord[i] = s_tdata[CW*i +: CW];
        end
    end

    ptd_dots u_dots (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .coord     (coord),
        .out_valid (dots_valid),
        .dot       (dots),
        .geom      (geom)
    );

    ptd_region u_region (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dots_valid),
        .dot       (dots),
        .geom      (geom),
        .out_valid (rg_valid),
        .num0      (num0),
        .den0      (den0),
        .num1      (num1),
        .den1      (den1),
        .tail      (rg_tail)
    );

    ptd_div #(.QB(QUOT_FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rg_valid),
        .num0      (num0),
        .den0      (den0),
        .num1      (num1),
        .den1      (den1),
        .tail_in   (rg_tail),
        .out_valid (dv_valid),
        .wt_v      (wt_v),
        .wt_w      (wt_w),
        .tail_out  (dv_tail)
    );

    ptd_dist #(.QB(QUOT_FRAC_BITS)) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (dv_valid),
        .wt_v       (wt_v),
        .wt_w       (wt_w),
        .tail_in    (dv_tail),
        .out_valid  (m_tvalid),
        .dist_sq    (dist_sq),
        .region     (region),
        .degenerate (degenerate)
    );

    assign m_tdata = {2'b00, degenerate, region, dist_sq};

    a_degen_face: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && degenerate |-> region == REG_FACE)
        else $error("degenerate flag outside face region");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_region_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> region != 3'd7)
        else $error("unused region code on output");

endmodule

### tb/tb_top.sv
// Testbench for the point-to-triangle squared distance pipeline.
`timescale 1ns / 1ps
module tb_top;
    import ptd_pkg::*;

    localparam int QFB = 16;
    localparam int LATENCY = QFB + 12;

    typedef struct {
        logic [DISTW-1:0] dist_sq;
        region_t          region;
        logic             degen;
    } tri_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    tri_result_t expected_q[$];
    int          n_errors;
    bit          stim_done;

    point_triangle_distance_sq_top #(.QUOT_FRAC_BITS(QFB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("point_triangle_distance_sq_top: mismatch");
        $finish;
    end

    function automatic longint dot3(longint u[3], longint v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic longint clamp_weight(logic signed [127:0] num,
                                            logic signed [127:0] den);
        if (den <= 0 || num < 0) return 0;
        if (num >= den) return longint'(1) << QFB;
        return longint'((num <<< QFB) / den);
    endfunction

    function automatic logic [DISTW-1:0] dist_to(longint p[3], longint base[3],
                                                 longint e1[3], longint v,
                                                 longint e2[3], longint w);
        longint one, s, t, r;
        logic [63:0] sum;
        one = longint'(1) << QFB;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            s = (p[i] - base[i]) * one - e1[i] * v - e2[i] * w;
            t = s + (one >>> 1);
            r = t >>> QFB;
            sum += 64'(r * r);
        end
        return (sum > 64'(DIST_MAX)) ? DIST_MAX : sum[DISTW-1:0];
    endfunction

    function automatic tri_result_t predict_closest(logic [191:0] d);
        longint p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        longint base[3], e1[3], e2[3];
        longint d1, d2, d3, d4, d5, d6, v, w;
        logic signed [127:0] va, vb, vc, den;
        tri_result_t res;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(d[16*i +: 16]));
            a[i] = longint'($signed(d[16*(3+i) +: 16]));
            b[i] = longint'($signed(d[16*(6+i) +: 16]));
            c[i] = longint'($signed(d[16*(9+i) +: 16]));
            ab[i] = b[i] - a[i]; ac[i] = c[i] - a[i]; bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i]; bp[i] = p[i] - b[i]; cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab, ap); d2 = dot3(ac, ap);
        d3 = dot3(ab, bp); d4 = dot3(ac, bp);
        d5 = dot3(ab, cp); d6 = dot3(ac, cp);
        vc = 128'(d1) * 128'(d4) - 128'(d3) * 128'(d2);
        vb = 128'(d5) * 128'(d2) - 128'(d1) * 128'(d6);
        va = 128'(d3) * 128'(d6) - 128'(d5) * 128'(d4);
        base = a; e1 = ab; e2 = ac; v = 0; w = 0;
        res.degen = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            res.region = REG_VA;
        end else if (d3 >= 0 && d4 <= d3) begin
            res.region = REG_VB; base = b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            res.region = REG_EAB;
            v = clamp_weight(128'(d1), 128'(d1 - d3));
        end else if (d6 >= 0 && d5 <= d6) begin
            res.region = REG_VC; base = c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            res.region = REG_EAC;
            w = clamp_weight(128'(d2), 128'(d2 - d6));
        end else if (va <= 0 && (d4 - d3) >= 0 && (d5 - d6) >= 0) begin
            res.region = REG_EBC; base = b; e1 = bc;
            v = clamp_weight(128'(d4 - d3), 128'((d4 - d3) + (d5 - d6)));
        end else begin
            res.region = REG_FACE;
            den = va + vb + vc;
            if (den <= 0) begin
                res.degen = 1'b1;
            end else begin
                v = clamp_weight(vb, den);
                w = clamp_weight(vc, den);
            end
        end
        res.dist_sq = dist_to(p, base, e1, v, e2, w);
        return res;
    endfunction

    task automatic send_query(logic [191:0] data);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        expected_q.insert(expected_q.size(), predict_closest(data));
        @(negedge aclk);
    endtask

    task automatic send_tri(logic [15:0] c[12]);
        logic [191:0] d;
        for (int i = 0; i < 12; i++) d[16*i +: 16] = c[i];
        send_query(d);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_q.size() != 0) @(negedge aclk);
    endtask

    task automatic test_extremes();
        logic [15:0] c[12];
        foreach (c[i]) c[i] = 16'h8000;
        send_tri(c);
        foreach (c[i]) c[i] = 16'h7fff;
        send_tri(c);
        foreach (c[i]) c[i] = (i % 2) ? 16'h7fff : 16'h8000;
        send_tri(c);
        foreach (c[i]) c[i] = 16'h0000;
        send_tri(c);
        // far point, all vertices at the opposite corner: widest distance
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
        send_tri(c);
    endtask

    task automatic test_regions();
        logic [15:0] c[12];
        // triangle a=(0,0,0) b=(4096,0,0) c=(0,4096,0), point z 1000 or -777
        c = '{-16'sd500, -16'sd500, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{16'sd5000, -16'sd100, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{16'sd2000, -16'sd300, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{-16'sd100, 16'sd5000, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{-16'sd300, 16'sd2000, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{16'sd3000, 16'sd3000, 16'sd1000, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        c = '{16'sd1000, 16'sd1000, -16'sd777, 0, 0, 0, 4096, 0, 0, 0, 4096, 0};
        send_tri(c);
        // collinear vertices: closest feature is edge ab
        c = '{16'sd100, 16'sd900, 16'sd50, 0, 0, 0, 4096, 0, 0, 8192, 0, 0};
        send_tri(c);
        // a == b: zero-length edge
        c = '{16'sd100, -16'sd900, 16'sd50, 0, 0, 0, 0, 0, 0, 0, 4096, 0};
        send_tri(c);
        // all three vertices equal
        c = '{16'sd321, -16'sd123, 16'sd77, 16'sd9, 16'sd9, 16'sd9,
              16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9, 16'sd9};
        send_tri(c);
    endtask

    task automatic test_random(int count);
        logic [191:0] d;
        logic [15:0] c[12];
        int sh;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            case ($urandom_range(0, 3))
                0: begin
                    for (int i = 0; i < 6; i++) d[32*i +: 32] = $urandom();
                    send_query(d);
                end
                default: begin
                    // small-scale geometry spreads the choice of region
                    sh = $urandom_range(4, 15);
                    foreach (c[i]) c[i] = 16'($signed(32'($urandom()) >>> (32 - sh)));
                    send_tri(c);
                end
            endcase
        end
    endtask

    initial begin
        int idle;
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (stim_done && expected_q.size() == 0) begin
                m_tready <= 1'b1;
            end else if (idle > 0) begin
                m_tready <= 1'b0;
                idle--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 1)) idle = $urandom_range(0, 3);
            end
        end
    end

    always @(posedge aclk) begin
        tri_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                n_errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (m_tdata[33:0] !== exp_r.dist_sq) begin
                    $error("dist_sq expected %0d actual %0d", exp_r.dist_sq, m_tdata[33:0]);
                    n_errors++;
                end
                if (m_tdata[36:34] !== exp_r.region) begin
                    $error("region expected %0d actual %0d", exp_r.region, m_tdata[36:34]);
                    n_errors++;
                end
                if (m_tdata[37] !== exp_r.degen) begin
                    $error("degenerate expected %0d actual %0d", exp_r.degen, m_tdata[37]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int waited;
        n_errors  = 0;
        stim_done = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_regions();
        test_random(600);
        s_tvalid <= 1'b0;
        stim_done = 1;
        waited = 0;
        while (expected_q.size() != 0 && waited < 100000) begin
            @(negedge aclk);
            waited++;
        end
        repeat (LATENCY + 4) @(negedge aclk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("point_triangle_distance_sq_top: match");
        end else begin
            $display("point_triangle_distance_sq_top: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
rtl/ptd_pkg.sv
rtl/ptd_dots.sv
rtl/ptd_region.sv
rtl/ptd_div.sv
rtl/ptd_dist.sv
rtl/point_triangle_distance_sq_top.sv
tb/tb_top.sv
